>>> rtl/windowed_median_filter_defines.svh
// ---------------------------------------------------------------------------
// Windowed median filter assertion macros
// Shared property wrappers for the checks at the end of the top level.
// ---------------------------------------------------------------------------
`ifndef WINDOWED_MEDIAN_FILTER_DEFINES_SVH
`define WINDOWED_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst.
`define WMF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst.
`define WMF_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/wmf_pkg.sv
// ---------------------------------------------------------------------------
// Windowed median filter package
// Field widths, register indexes, defaults and the sorter control type.
// ---------------------------------------------------------------------------
`default_nettype none

package wmf_pkg;

  // Fixed field widths.
  localparam int PIX_W     = 8;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 11;

  // Parameter defaults.
  localparam int DEF_WINDOW    = 5;
  localparam int DEF_MAX_WIDTH = 2048;

  // Register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     RST_IMAGE_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0]     RST_IMAGE_HEIGHT = CFG_W'(480);

  // Control from the sequencer to the sorter.
  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/wmf_ram.sv
// ---------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module wmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/wmf_sorter.sv
// ---------------------------------------------------------------------------
// Windowed median filter insertion sorter
// Takes one pixel per cycle into a sorted register row and gives the middle.
// ---------------------------------------------------------------------------
`default_nettype none

module wmf_sorter import wmf_pkg::*; #(
  parameter int ENTRIES = DEF_WINDOW * DEF_WINDOW
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sort_ctrl_t                   ctrl,
  input  wire logic [PIX_W-1:0]             din,
  output logic      [$clog2(ENTRIES+1)-1:0] count,
  output logic      [PIX_W-1:0]             median
);

  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = $clog2(ENTRIES);

  logic [PIX_W-1:0]   v [ENTRIES];
  logic [CNT_W-1:0]   n;
  logic [ENTRIES-1:0] gt;
  logic [IDX_W-1:0]   mid;

  // Flag the filled entries that are greater than the new pixel.
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      gt[k] = (CNT_W'(k) < n) && (v[k] > din);
    end
  end

  // Each entry shifts up, takes the new pixel, or holds.
  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    if (k == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (ctrl.insert && (gt[0] || n == '0)) begin
          v[0] <= din;
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (ctrl.insert) begin
          if (gt[k-1]) begin
            v[k] <= v[k-1];
          end else if (gt[k] || n == CNT_W'(k)) begin
            v[k] <= din;
          end
        end
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
    end else if (ctrl.clear) begin
      n <= '0;
    end else if (ctrl.insert) begin
      n <= n + 1'b1;
    end
  end

  // The entry at half the count is the (upper) median.
  assign mid    = IDX_W'(n >> 1);
  assign median = v[mid];
  assign count  = n;

endmodule

`default_nettype wire

>>> rtl/windowed_median_filter.sv
// ---------------------------------------------------------------------------
// Windowed median filter
// Streaming WINDOW x WINDOW median over 8-bit raster frames.
// ---------------------------------------------------------------------------
// Pixels arrive in raster order and are written to a line store that holds
// the last WINDOW rows. An input request that completes no window leaves the
// sequencer idle. Otherwise it yields one to (WINDOW/2+1)^2 results in raster
// order, and each result sorts its n in-bounds window pixels (up to
// WINDOW*WINDOW, 25 at the default size): the line store's single read port
// feeds the insertion sorter one pixel per cycle. The next request is taken
// once the last result of the current one sits in the output register. The
// line store has no clearing pass; a write to the width or height register
// restarts the frame at row 0, column 0. Configure only while idle.
`default_nettype none
`include "windowed_median_filter_defines.svh"

module windowed_median_filter import wmf_pkg::*; #(
  parameter int WINDOW    = DEF_WINDOW,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  // Pixel input
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PIX_W-1:0]     pixel,
  // Median output
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic      [PIX_W-1:0]     median_value,
  output logic      [ROW_W-1:0]     out_row,
  output logic      [OUT_COL_W-1:0] out_col,
  output logic                      end_of_frame,
  output logic                      last
);

  localparam int HALF    = WINDOW / 2;
  localparam int ENTRIES = WINDOW * WINDOW;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int DEPTH   = WINDOW * MAX_WIDTH;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int SLOT_W  = $clog2(WINDOW);
  localparam int COL_W   = $clog2(MAX_WIDTH);

  localparam logic [ROW_W-1:0]  HALF_R   = ROW_W'(HALF);
  localparam logic [COL_W-1:0]  HALF_C   = COL_W'(HALF);
  localparam logic [SLOT_W-1:0] SLOT_TOP = SLOT_W'(WINDOW - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WIN   = 6'b000010,
    S_SLOT  = 6'b000100,
    S_WALK  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_PICK  = 6'b100000
  } state_t;

  state_t state;

  // Configuration and input position.
  logic [CFG_W-1:0]  image_width;
  logic [CFG_W-1:0]  image_height;
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [SLOT_W-1:0] in_slot;

  // Item being worked on and its result range.
  logic [ROW_W-1:0]  cur_row;
  logic [SLOT_W-1:0] cur_slot;
  logic [ROW_W-1:0]  res_row;
  logic [COL_W-1:0]  res_col;
  logic [ROW_W-1:0]  res_row_end;
  logic [COL_W-1:0]  res_col_first;
  logic [COL_W-1:0]  res_col_end;

  // Window bounds and walk counters.
  logic [ROW_W-1:0]  wr_lo;
  logic [ROW_W-1:0]  wr_hi;
  logic [COL_W-1:0]  wc_lo;
  logic [COL_W-1:0]  wc_hi;
  logic [ROW_W-1:0]  walk_row;
  logic [COL_W-1:0]  walk_col;
  logic [SLOT_W-1:0] walk_slot;
  logic              rd_pending;

  // Effective frame size.
  logic [ROW_W-1:0] rows_m1;
  logic [COL_W-1:0] cols_m1;

  // Accept decode.
  logic              accept;
  logic              wrap;
  logic [ROW_W-1:0]  acc_row;
  logic [COL_W-1:0]  acc_col;
  logic [SLOT_W-1:0] acc_slot;
  logic              row_last;
  logic              col_last;
  logic              row_ge;
  logic              col_ge;
  logic [ROW_W-1:0]  row_back;
  logic [COL_W-1:0]  col_back;
  logic              has_out;

  // Window and slot arithmetic.
  logic [ROW_W:0]    row_sum;
  logic [COL_W:0]    col_sum;
  logic [ROW_W-1:0]  win_row_lo;
  logic [ROW_W-1:0]  win_row_hi;
  logic [COL_W-1:0]  win_col_lo;
  logic [COL_W-1:0]  win_col_hi;
  logic [SLOT_W-1:0] lag;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] slot_start;
  logic              walk_done;

  // Store ports, sorter and output load.
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [PIX_W-1:0]  rd_data;
  sort_ctrl_t        sort_ctrl;
  logic [CNT_W-1:0]  sort_count;
  logic [PIX_W-1:0]  sort_median;
  logic              load;
  logic              res_done;

  // Effective height and width with out-of-range values folded in.
  always_comb begin
    rows_m1 = (image_height == '0) ? '0 : image_height - 1'b1;
    if (image_width == '0) begin
      cols_m1 = '0;
    end else if ({1'b0, image_width} > (CFG_W+1)'(MAX_WIDTH)) begin
      cols_m1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      cols_m1 = COL_W'(image_width - 1'b1);
    end
  end

  // Position of the accepted pixel and the results it releases.
  always_comb begin
    accept   = in_valid && (state == S_IDLE);
    wrap     = (in_row > rows_m1) || (in_col > cols_m1);
    acc_row  = wrap ? '0 : in_row;
    acc_col  = wrap ? '0 : in_col;
    acc_slot = wrap ? '0 : in_slot;
    row_last = acc_row == rows_m1;
    col_last = acc_col == cols_m1;
    row_ge   = acc_row >= HALF_R;
    col_ge   = acc_col >= HALF_C;
    row_back = row_ge ? acc_row - HALF_R : '0;
    col_back = col_ge ? acc_col - HALF_C : '0;
    has_out  = (row_last || row_ge) && (col_last || col_ge);
  end

  // Window around the current result, clipped to the frame.
  always_comb begin
    row_sum    = {1'b0, res_row} + {1'b0, HALF_R};
    col_sum    = {1'b0, res_col} + {1'b0, HALF_C};
    win_row_lo = (res_row >= HALF_R) ? res_row - HALF_R : '0;
    win_col_lo = (res_col >= HALF_C) ? res_col - HALF_C : '0;
    win_row_hi = (row_sum > {1'b0, rows_m1}) ? rows_m1 : row_sum[ROW_W-1:0];
    win_col_hi = (col_sum > {1'b0, cols_m1}) ? cols_m1 : col_sum[COL_W-1:0];
  end

  // Store slot of the window's top row, counted back from the item's row.
  always_comb begin
    lag        = SLOT_W'(cur_row - wr_lo);
    slot_sum   = {1'b0, cur_slot} + (SLOT_W+1)'(WINDOW);
    slot_start = (cur_slot >= lag) ? cur_slot - lag : SLOT_W'(slot_sum - {1'b0, lag});
    walk_done  = (walk_row == wr_hi) && (walk_col == wc_hi);
  end

  assign wr_addr = ADDR_W'(acc_slot * MAX_WIDTH) + ADDR_W'(acc_col);
  assign rd_addr = ADDR_W'(walk_slot * MAX_WIDTH) + ADDR_W'(walk_col);

  assign in_stall = state != S_IDLE;
  assign load     = (state == S_PICK) && (!out_valid || !out_stall);
  assign res_done = (res_row == res_row_end) && (res_col == res_col_end);

  assign sort_ctrl.clear  = state == S_WIN;
  assign sort_ctrl.insert = rd_pending;

  // Line store.
  wmf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_addr),
    .wdata (pixel),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Shared insertion sorter.
  wmf_sorter #(
    .ENTRIES (ENTRIES)
  ) u_sorter (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (sort_ctrl),
    .din    (rd_data),
    .count  (sort_count),
    .median (sort_median)
  );

  // Configuration registers and input position.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      in_row       <= '0;
      in_col       <= '0;
      in_slot      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_data;
          in_row      <= '0;
          in_col      <= '0;
          in_slot     <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_data;
          in_row       <= '0;
          in_col       <= '0;
          in_slot      <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (col_last) begin
        in_col <= '0;
        if (row_last) begin
          in_row  <= '0;
          in_slot <= '0;
        end else begin
          in_row  <= acc_row + 1'b1;
          in_slot <= (acc_slot == SLOT_TOP) ? '0 : acc_slot + 1'b1;
        end
      end else begin
        in_row <= acc_row;
        in_col <= acc_col + 1'b1;
      end
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= state == S_WALK;
      case (state)
        S_IDLE: begin
          if (accept && has_out) begin
            state <= S_WIN;
          end
        end
        S_WIN: begin
          state <= S_SLOT;
        end
        S_SLOT: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (walk_done) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_PICK;
        end
        S_PICK: begin
          if (load) begin
            state <= res_done ? S_IDLE : S_WIN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_row       <= acc_row;
      cur_slot      <= acc_slot;
      res_row       <= row_back;
      res_col       <= col_back;
      res_row_end   <= row_last ? acc_row : row_back;
      res_col_first <= col_back;
      res_col_end   <= col_last ? acc_col : col_back;
    end
    if (state == S_WIN) begin
      wr_lo <= win_row_lo;
      wr_hi <= win_row_hi;
      wc_lo <= win_col_lo;
      wc_hi <= win_col_hi;
    end
    if (state == S_SLOT) begin
      walk_row  <= wr_lo;
      walk_col  <= wc_lo;
      walk_slot <= slot_start;
    end
    // Column first, then the next row and its store slot.
    if (state == S_WALK) begin
      if (walk_col == wc_hi) begin
        walk_col  <= wc_lo;
        walk_row  <= walk_row + 1'b1;
        walk_slot <= (walk_slot == SLOT_TOP) ? '0 : walk_slot + 1'b1;
      end else begin
        walk_col <= walk_col + 1'b1;
      end
    end
    // Step to the next result position in raster order.
    if (load && !res_done) begin
      if (res_col == res_col_end) begin
        res_col <= res_col_first;
        res_row <= res_row + 1'b1;
      end else begin
        res_col <= res_col + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      median_value <= sort_median;
      out_row      <= res_row;
      out_col      <= OUT_COL_W'(res_col);
      end_of_frame <= (res_row == rows_m1) && (res_col == cols_m1);
      last         <= res_done;
    end
  end

  // Checks on the sequencer.
  `WMF_ASSERT_IMP(a_sort_count, state == S_PICK,
    sort_count == CNT_W'((wr_hi - wr_lo + 1) * (wc_hi - wc_lo + 1)),
    "sorter count does not match the window size")
  `WMF_ASSERT_NXT(a_last_to_idle, load && res_done, state == S_IDLE,
    "sequencer did not return to idle after the last result")
  `WMF_ASSERT_NXT(a_no_result_idle, accept && !has_out, state == S_IDLE && !rd_pending,
    "request without results started a window walk")

endmodule

`default_nettype wire

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Windowed median filter testbench
// Streams raster frames of small and edge-case sizes through the filter.
// A built-in line store mirror predicts every median with its row, column,
// end-of-frame and last flags. The monitor checks each result against the
// oldest prediction under random sender idles and receiver stalls, by mode.
// ---------------------------------------------------------------------------
module testbench import wmf_pkg::*;;

  localparam int WIN  = DEF_WINDOW;
  localparam int HALF = WIN / 2;
  localparam int MAXW = DEF_MAX_WIDTH;

  // Register indexes past the end of the register list; writes must do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = CFG_IDX_W'(3);

  localparam int RANDOM_PIXELS  = 175;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [PIX_W-1:0]     median_value;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 end_of_frame;
    logic                 last;
  } median_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [PIX_W-1:0]     pixel = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [PIX_W-1:0]     median_value;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 end_of_frame;
  logic                 last;

  windowed_median_filter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_value (median_value),
    .out_row      (out_row),
    .out_col      (out_col),
    .end_of_frame (end_of_frame),
    .last         (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mirror of the filter: line store, frame position and size registers.
  logic [PIX_W-1:0] row_store [WIN][MAXW];
  logic [CFG_W-1:0] width_setting  = RST_IMAGE_WIDTH;
  logic [CFG_W-1:0] height_setting = RST_IMAGE_HEIGHT;
  int               next_row = 0;
  int               next_col = 0;

  median_result_t   pending_medians [$];
  logic [PIX_W-1:0] pixel_queue [$];

  int pixels_pushed   = 0;
  int pixels_accepted = 0;
  int medians_checked = 0;
  int error_count     = 0;
  int quiet_cycles    = 0;
  int size_settings   = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  bit in_taken = 1'b0;

  function automatic int active_width();
    if (width_setting == 0) return 1;
    if (width_setting > MAXW) return MAXW;
    return int'(width_setting);
  endfunction

  function automatic int active_height();
    return (height_setting == 0) ? 1 : int'(height_setting);
  endfunction

  // Sort the in-bounds window pixels and take the upper median.
  function automatic logic [PIX_W-1:0] window_median(input int row, input int col,
                                                     input int rows, input int cols);
    logic [PIX_W-1:0] sorted [WIN*WIN];
    logic [PIX_W-1:0] x;
    int n;
    int k;
    n = 0;
    for (int i = row - HALF; i <= row + HALF; i++) begin
      for (int j = col - HALF; j <= col + HALF; j++) begin
        if (i < 0 || i >= rows || j < 0 || j >= cols) continue;
        x = row_store[i % WIN][j];
        k = n;
        while (k > 0 && sorted[k-1] > x) begin
          sorted[k] = sorted[k-1];
          k--;
        end
        sorted[k] = x;
        n++;
      end
    end
    return sorted[n/2];
  endfunction

  // Store one pixel and queue every median that its arrival completes.
  function automatic void filter_pixel(input logic [PIX_W-1:0] value);
    int cols, rows, r, c, r0, r1, c0, c1;
    median_result_t res;
    cols = active_width();
    rows = active_height();
    r = next_row;
    c = next_col;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    row_store[r % WIN][c] = value;

    // The last row flushes the trailing rows; otherwise one row lags by HALF.
    if (r == rows - 1) begin
      r0 = (r - HALF < 0) ? 0 : r - HALF;
      r1 = r;
    end else if (r >= HALF) begin
      r0 = r - HALF;
      r1 = r0;
    end else begin
      r0 = 0;
      r1 = -1;
    end
    if (c == cols - 1) begin
      c0 = (c - HALF < 0) ? 0 : c - HALF;
      c1 = c;
    end else if (c >= HALF) begin
      c0 = c - HALF;
      c1 = c0;
    end else begin
      c0 = 0;
      c1 = -1;
    end

    for (int i = r0; i <= r1; i++) begin
      for (int j = c0; j <= c1; j++) begin
        res.median_value = window_median(i, j, rows, cols);
        res.row          = ROW_W'(i);
        res.col          = OUT_COL_W'(j);
        res.end_of_frame = (i == rows - 1) && (j == cols - 1);
        res.last         = (i == r1) && (j == c1);
        pending_medians  = {pending_medians, res};
      end
    end

    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    next_row = r;
    next_col = c;
  endfunction

  function automatic void flag_mismatch(input string field, input median_result_t want,
                                        input int exp_val, input int act_val);
    $display("%0t: %s mismatch at row %0d col %0d: expected %0d, actual %0d",
             $time, field, want.row, want.col, exp_val, act_val);
    error_count++;
  endfunction

  // Monitor: check results, mirror accepted pixels, run the watchdog.
  always @(posedge clk) begin
    median_result_t want;
    in_taken = 1'b0;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_medians.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual median %0d row %0d col %0d",
                   $time, median_value, out_row, out_col);
          error_count++;
        end else begin
          want = pending_medians.pop_front();
          if (median_value !== want.median_value)
            flag_mismatch("median_value", want, want.median_value, median_value);
          if (out_row !== want.row)
            flag_mismatch("out_row", want, want.row, out_row);
          if (out_col !== want.col)
            flag_mismatch("out_col", want, want.col, out_col);
          if (end_of_frame !== want.end_of_frame)
            flag_mismatch("end_of_frame", want, want.end_of_frame, end_of_frame);
          if (last !== want.last)
            flag_mismatch("last", want, want.last, last);
          medians_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        in_taken = 1'b1;
        filter_pixel(pixel);
        pixels_accepted++;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, no request moved for %0d cycles", $time, quiet_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Pixel driver: holds a stalled request, otherwise sends or idles at random.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pixel_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        pixel    <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
        pixel    <= PIX_W'($urandom_range(255));
      end
    end
  end

  // Receiver stall.
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < receiver_stall_pct);
  end

  task automatic wait_idle();
    while (pixels_accepted != pixels_pushed || pending_medians.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write, issued only once the filter has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
      if (idx == REG_IMAGE_WIDTH) width_setting = data;
      else height_setting = data;
      next_row = 0;
      next_col = 0;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic void queue_pixel(input logic [PIX_W-1:0] value);
    pixel_queue = {pixel_queue, value};
    pixels_pushed++;
  endfunction

  // Random pixels lean toward black and white to force ties in the sort.
  function automatic logic [PIX_W-1:0] random_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  // Stimulus: directed edge cases, then random frame settings.
  initial begin
    int w, h, n, shape;
    idle_mode_t mode;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default size: a couple of pixels that complete no window.
    queue_pixel(8'h00);
    queue_pixel(8'hFF);

    // Zero sizes act as one, so each pixel is a whole frame.
    write_reg(REG_IMAGE_WIDTH, 12'h000);
    write_reg(REG_IMAGE_HEIGHT, 12'h000);
    queue_pixel(8'hFF);
    queue_pixel(8'h00);

    // One column: the last row flushes the whole column.
    write_reg(REG_IMAGE_WIDTH, 12'd1);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    queue_pixel(8'hFF);
    queue_pixel(8'h00);
    queue_pixel(8'hFF);

    // Two pixels in one row: even counts take the upper median.
    write_reg(REG_IMAGE_WIDTH, 12'd2);
    write_reg(REG_IMAGE_HEIGHT, 12'd1);
    queue_pixel(8'h0A);
    queue_pixel(8'hC8);

    // Three by three: the final pixel flushes nine results.
    write_reg(REG_IMAGE_WIDTH, 12'd3);
    write_reg(REG_IMAGE_HEIGHT, 12'd3);
    queue_pixel(8'hFF);
    queue_pixel(8'h00);
    queue_pixel(8'h80);
    queue_pixel(8'h01);
    queue_pixel(8'hFE);
    queue_pixel(8'h7F);
    queue_pixel(8'h00);
    queue_pixel(8'hFF);
    queue_pixel(8'h40);

    // Oversized width clamps; writes past the register list keep the position.
    write_reg(REG_IMAGE_WIDTH, 12'hFFF);
    write_reg(REG_IMAGE_HEIGHT, 12'd1);
    repeat (4) queue_pixel(random_pixel());
    write_reg(REG_UNUSED_2, 12'hFFF);
    repeat (2) queue_pixel(random_pixel());
    write_reg(REG_UNUSED_3, 12'h000);
    queue_pixel(random_pixel());

    // Random frame settings, rotating through the idle modes.
    n = pixels_pushed + RANDOM_PIXELS;
    while (pixels_pushed < n) begin
      mode = idle_mode_t'(size_settings % 4);
      wait_idle();
      case (mode)
        IDLE_NONE: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        IDLE_SENDER: begin
          sender_idle_pct    = 82;
          receiver_stall_pct = 0;
        end
        IDLE_RECEIVER: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 82;
        end
        default: begin
          sender_idle_pct    = 20;
          receiver_stall_pct = 20;
        end
      endcase
      size_settings++;
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3, CFG_W'($urandom));

      shape = $urandom_range(99);
      if (shape < 85) begin
        // Small frame, whole, doubled or cut short.
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 8);
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        if ($urandom_range(4) != 0) write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        w = active_width() * active_height();
        if (shape < 12) w = 2 * w;
        else if (shape >= 70) w = (w > 1) ? $urandom_range(1, w - 1) : 1;
      end else if (shape < 93) begin
        // A zero size, which acts as one.
        if ($urandom_range(1)) begin
          write_reg(REG_IMAGE_WIDTH, 12'h000);
          write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 7)));
        end else begin
          write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(1, 7)));
          write_reg(REG_IMAGE_HEIGHT, 12'h000);
        end
        w = active_width() * active_height();
      end else begin
        // Widest rows, sent only in part.
        case ($urandom_range(2))
          0: write_reg(REG_IMAGE_WIDTH, 12'hFFF);
          1: write_reg(REG_IMAGE_WIDTH, CFG_W'(MAXW));
          default: write_reg(REG_IMAGE_WIDTH, CFG_W'(MAXW - 1));
        endcase
        write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 2)));
        w = $urandom_range(3, 30);
      end
      // Keep the total pixel count near the target.
      if (w > n - pixels_pushed) w = n - pixels_pushed;
      repeat (w) queue_pixel(random_pixel());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d pixels over %0d random size settings plus directed cases,",
             pixels_accepted, size_settings);
    $display("checked %0d medians under no idling, sender gaps, stalls and both.",
             medians_checked);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/wmf_pkg.sv
rtl/wmf_ram.sv
rtl/wmf_sorter.sv
rtl/windowed_median_filter.sv
dv/testbench.sv
